@@ rtl/tvpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tvpc_pkg: shared types and constants
// Widths, register map and small arithmetic helpers for the cull core.
// ----------------------------------------------------------------------------
package tvpc_pkg;

  localparam int unsigned CoordW   = 20;
  localparam int unsigned AxisW    = 16;
  localparam int unsigned CamW     = 40;   // Q.22 camera coordinate
  localparam int unsigned RedW     = 22;   // Q.4 culling coordinate
  localparam int unsigned DivBits  = 4;    // quotient bits per divider stage
  localparam int unsigned DivLat   = 64 / DivBits; // divider stages
  localparam logic signed [CamW-1:0] NearLimit = 40'sd41944;

  localparam int unsigned AddrW = 6;
  localparam logic [AddrW-1:0] RegCamPos  = 6'd0;
  localparam logic [AddrW-1:0] RegRight   = 6'd8;
  localparam logic [AddrW-1:0] RegUp      = 6'd16;
  localparam logic [AddrW-1:0] RegForward = 6'd24;
  localparam logic [AddrW-1:0] RegFocal   = 6'd32;
  localparam logic [AddrW-1:0] RegWidth   = 6'd40;
  localparam logic [AddrW-1:0] RegHeight  = 6'd48;

  typedef struct packed {
    logic [59:0] cam_pos;
    logic [47:0] right;
    logic [47:0] up;
    logic [47:0] fwd;
    logic [23:0] focal;
    logic [12:0] width;
    logic [12:0] height;
  } cfg_t;

  typedef logic signed [CamW-1:0] cam_t;

  // Truncate Q.22 toward zero to Q.4
  function automatic logic signed [RedW-1:0] reduce(input cam_t v);
    logic signed [CamW-1:0] a;
    a = (v < 0) ? (v + 40'sd262143) : v;
    return a[CamW-1 -: RedW];
  endfunction

endpackage

@@ rtl/tvpc_xform.sv @@
// ----------------------------------------------------------------------------
// tvpc_xform: view transform of one vertex
// Subtract camera position, then three registered dot products.
// ----------------------------------------------------------------------------
module tvpc_xform
  import tvpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  cfg_t              cfg_i,
  input  logic [3*CoordW-1:0] vtx_i,
  output cam_t              cam_x_o,
  output cam_t              cam_y_o,
  output cam_t              cam_z_o
);

  logic signed [CoordW:0] d_q [3];
  logic signed [CoordW:0] d_d [3];
  cam_t x_d, y_d, z_d, x_q, y_q, z_q;

  // Subtract camera position
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_d[k] = (CoordW+1)'($signed(vtx_i[k*CoordW +: CoordW]))
             - (CoordW+1)'($signed(cfg_i.cam_pos[k*CoordW +: CoordW]));
    end
  end

  // Dot with the three basis vectors
  always_comb begin
    x_d = '0; y_d = '0; z_d = '0;
    for (int k = 0; k < 3; k++) begin
      x_d = x_d + CamW'(d_q[k]) * CamW'($signed(cfg_i.right[k*AxisW +: AxisW]));
      y_d = y_d + CamW'(d_q[k]) * CamW'($signed(cfg_i.up[k*AxisW +: AxisW]));
      z_d = z_d + CamW'(d_q[k]) * CamW'($signed(cfg_i.fwd[k*AxisW +: AxisW]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
      x_q <= x_d; y_q <= y_d; z_q <= z_d;
    end
  end

  assign cam_x_o = x_q;
  assign cam_y_o = y_q;
  assign cam_z_o = z_q;

endmodule

@@ rtl/tvpc_div.sv @@
// ----------------------------------------------------------------------------
// tvpc_div: pipelined signed divider
// Restoring division of a 64-bit magnitude by a 48-bit magnitude, a few
// quotient bits per stage, truncating toward zero; the quotient sign rides along.
// ----------------------------------------------------------------------------
module tvpc_div
  import tvpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] num_i,
  input  logic signed [47:0] den_i,
  output logic signed [63:0] quo_o
);

  logic [63:0] n_q [DivLat+1];
  logic [63:0] q_q [DivLat+1];
  logic [47:0] dv_q [DivLat+1];
  logic [48:0] r_q [DivLat+1];
  logic        neg_q [DivLat+1];

  assign n_q[0]   = num_i[63] ? 64'(-num_i) : num_i;
  assign dv_q[0]  = den_i[47] ? 48'(-den_i) : den_i;
  assign r_q[0]   = '0;
  assign q_q[0]   = '0;
  assign neg_q[0] = num_i[63] ^ den_i[47];

  for (genvar s = 0; s < DivLat; s++) begin : g_stage
    logic [48:0] r_d;
    logic [63:0] q_d, n_d;
    // Restoring steps for this stage
    always_comb begin
      logic [49:0] t;
      r_d = r_q[s]; q_d = q_q[s]; n_d = n_q[s];
      for (int b = 0; b < DivBits; b++) begin
        t = {r_d, n_d[63]};
        n_d = {n_d[62:0], 1'b0};
        if (t >= {2'b00, dv_q[s]}) begin
          t = t - {2'b00, dv_q[s]};
          q_d = {q_d[62:0], 1'b1};
        end else begin
          q_d = {q_d[62:0], 1'b0};
        end
        r_d = t[48:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1] <= r_d; q_q[s+1] <= q_d; n_q[s+1] <= n_d;
        dv_q[s+1] <= dv_q[s]; neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign quo_o = neg_q[DivLat] ? -$signed(q_q[DivLat]) : $signed(q_q[DivLat]);

endmodule

@@ rtl/triangle_view_project_cull_core.sv @@
// ----------------------------------------------------------------------------
// triangle_view_project_cull_core: triangle view transform, cull, projection
// Usage: triangles enter on s_axis (nine Q12.8 world coordinates) and leave
// on m_axis (screen x, y and Q8.24 inverse depth per vertex). Culled
// triangles produce no output word. Camera registers are to be written over
// APB at byte addresses 8*i only while the block is idle; the block does
// not enforce this. Throughput: one triangle per cycle unless m_axis stalls.
// An accepted input word passes a subtract stage and a dot-product stage, a
// cull stage, an operand stage, the 16-stage divider chain that produces the
// projected coordinates and inverse depths, and the output register.
// Reset clears all valid bits and loads the default camera (identity axes,
// origin, focal 256, 640x480).
// Stall: the whole pipeline advances only when the output register is
// empty or being taken, so s_axis_tready is low exactly while a word waits
// on m_axis with m_axis_tready low.
// ----------------------------------------------------------------------------
module triangle_view_project_cull_core
  import tvpc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (20 bits each), 4 pad bits
  input  logic [183:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // a_screen_x, a_screen_y, a_inv_depth, b_..., c_... (16,16,32 each)
  output logic [191:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int unsigned Depth  = 4 + DivLat; // valid pipe length

  cfg_t cfg_q;
  logic adv;
  logic [Depth-1:0] vld_q;
  logic out_vld_q;
  logic [191:0] out_q;

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_pos <= '0;
      cfg_q.right   <= 48'd16384;
      cfg_q.up      <= 48'd1073741824;
      cfg_q.fwd     <= 48'd70368744177664;
      cfg_q.focal   <= 24'd65536;
      cfg_q.width   <= 13'd640;
      cfg_q.height  <= 13'd480;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        RegCamPos:  cfg_q.cam_pos <= pwdata[59:0];
        RegRight:   cfg_q.right   <= pwdata[47:0];
        RegUp:      cfg_q.up      <= pwdata[47:0];
        RegForward: cfg_q.fwd     <= pwdata[47:0];
        RegFocal:   cfg_q.focal   <= pwdata[23:0];
        RegWidth:   cfg_q.width   <= pwdata[12:0];
        RegHeight:  cfg_q.height  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegCamPos:  prdata = {4'd0, cfg_q.cam_pos};
      RegRight:   prdata = {16'd0, cfg_q.right};
      RegUp:      prdata = {16'd0, cfg_q.up};
      RegForward: prdata = {16'd0, cfg_q.fwd};
      RegFocal:   prdata = {40'd0, cfg_q.focal};
      RegWidth:   prdata = {51'd0, cfg_q.width};
      RegHeight:  prdata = {51'd0, cfg_q.height};
      default:    prdata = '0;
    endcase
  end

  // Advance when output slot frees
  assign adv = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1-2: view transform
  cam_t cx [3], cy [3], cz [3];
  for (genvar v = 0; v < 3; v++) begin : g_xf
    tvpc_xform u_xf (
      .clk_i   (clk_i),
      .en_i    (adv),
      .cfg_i   (cfg_q),
      .vtx_i   (s_axis_tdata[v*60 +: 60]),
      .cam_x_o (cx[v]),
      .cam_y_o (cy[v]),
      .cam_z_o (cz[v])
    );
  end

  // Stage 3: cull decision and projection numerators
  logic keep_d, keep_s4_d;
  logic signed [RedW-1:0] r [3][3];
  logic signed [RedW:0] u1 [3], u2 [3];
  logic signed [RedW+1:0] sm [3];
  logic signed [47:0] nrm [3];
  logic signed [63:0] num_x_d [3], num_y_d [3];
  logic signed [63:0] num_x_q [3], num_y_q [3];
  logic signed [47:0] nrm_q [3];
  logic signed [RedW+1:0] sm_q [3];
  cam_t z3_q [3];
  logic near_q;
  logic signed [63:0] dot;

  always_comb begin
    logic near;
    near = 1'b0;
    for (int v = 0; v < 3; v++) begin
      r[v][0] = reduce(cx[v]);
      r[v][1] = reduce(cy[v]);
      r[v][2] = reduce(cz[v]);
      if (cz[v] < NearLimit && cz[v] > -NearLimit) near = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      u1[k] = (RedW+1)'(r[1][k]) - (RedW+1)'(r[0][k]);
      u2[k] = (RedW+1)'(r[2][k]) - (RedW+1)'(r[0][k]);
      sm[k] = (RedW+2)'(r[0][k]) + (RedW+2)'(r[1][k]) + (RedW+2)'(r[2][k]);
    end
    nrm[0] = 48'(u1[1]) * 48'(u2[2]) - 48'(u1[2]) * 48'(u2[1]);
    nrm[1] = 48'(u1[2]) * 48'(u2[0]) - 48'(u1[0]) * 48'(u2[2]);
    nrm[2] = 48'(u1[0]) * 48'(u2[1]) - 48'(u1[1]) * 48'(u2[0]);
    for (int v = 0; v < 3; v++) begin
      num_x_d[v] = 64'(cx[v]) * 64'($signed({1'b0, cfg_q.focal}));
      num_y_d[v] = -(64'(cy[v]) * 64'($signed({1'b0, cfg_q.focal})));
    end
    keep_d = !near;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        nrm_q[k] <= nrm[k];
        sm_q[k]  <= sm[k];
        num_x_q[k] <= num_x_d[k];
        num_y_q[k] <= num_y_d[k];
        z3_q[k]  <= cz[k];
      end
      near_q <= !keep_d;
    end
  end

  // Stage 4: facing test, divider operands
  assign dot = 64'(nrm_q[0]) * 64'(sm_q[0]) + 64'(nrm_q[1]) * 64'(sm_q[1])
             + 64'(nrm_q[2]) * 64'(sm_q[2]);
  assign keep_s4_d = !near_q && !(nrm_q[0] == 0 && nrm_q[1] == 0 && nrm_q[2] == 0)
                     && !dot[63];

  logic signed [63:0] tx [3], ty [3], ti [3];
  logic signed [47:0] dn [3], dz [3];
  logic keep_s4_q;
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      tx[v] = 2 * num_x_q[v] + 64'(z3_q[v]) * 256 * 64'({1'b0, cfg_q.width} + 14'd1);
      ty[v] = 2 * num_y_q[v] + 64'(z3_q[v]) * 256 * 64'({1'b0, cfg_q.height} + 14'd1);
      ti[v] = 64'sd1 <<< 46;
      dn[v] = 48'(z3_q[v]) * 512;
      dz[v] = 48'(z3_q[v]);
    end
  end
  logic signed [63:0] tx_q [3], ty_q [3];
  logic signed [47:0] dn_q [3], dz_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q <= tx; ty_q <= ty; dn_q <= dn; dz_q <= dz;
      keep_s4_q <= keep_s4_d;
    end
  end

  // Stages 5..: dividers
  logic signed [63:0] qx [3], qy [3], qi [3];
  for (genvar v = 0; v < 3; v++) begin : g_dv
    tvpc_div u_dx (.clk_i(clk_i), .en_i(adv), .num_i(tx_q[v]), .den_i(dn_q[v]),
                   .quo_o(qx[v]));
    tvpc_div u_dy (.clk_i(clk_i), .en_i(adv), .num_i(ty_q[v]), .den_i(dn_q[v]),
                   .quo_o(qy[v]));
    tvpc_div u_di (.clk_i(clk_i), .en_i(adv), .num_i(ti[v]), .den_i(dz_q[v]),
                   .quo_o(qi[v]));
  end

  // Keep flags travel alongside the divider chain
  logic [DivLat-1:0] keep_pipe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      keep_pipe_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
      keep_pipe_q <= {keep_pipe_q[DivLat-2:0], keep_s4_q};
    end
  end

  function automatic logic [15:0] sat16(input logic signed [63:0] q);
    if (q > 64'sd32767) return 16'h7fff;
    if (q < -64'sd32768) return 16'h8000;
    return q[15:0];
  endfunction

  // Output register
  logic [191:0] out_d;
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      out_d[v*64 +: 64] = {qi[v][31:0], sat16(qy[v]), sat16(qx[v])};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= vld_q[Depth-1] && keep_pipe_q[DivLat-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ rtl/tvpc_checker.sv @@
// ----------------------------------------------------------------------------
// tvpc_checker: port-level checks
// Observes the handshakes of the core and flags protocol slips.
// ----------------------------------------------------------------------------
module tvpc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic pready
);

  // Keep output valid while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("drop");
  // Input opens whenever output is taken
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready) else $error("ready");
  // Stalled output blocks input
  a_blk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("block");
  a_pr: assert property (@(posedge clk_i) pready) else $error("pready");

endmodule

bind triangle_view_project_cull_core tvpc_checker u_chk (.*);

@@ tb/triangle_view_project_cull_core_checker.sv @@
// ----------------------------------------------------------------------------
// triangle_view_project_cull_core_checker: scoreboard for the cull core
// Watches the APB port, the triangle stream and the screen stream. Keeps a
// copy of the camera registers, works out which triangles survive the near,
// degenerate and facing tests and what they project to, and compares every
// output word field by field with the oldest outstanding projection.
// ----------------------------------------------------------------------------
module triangle_view_project_cull_core_checker
  import tvpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [183:0]     s_axis_tdata,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [191:0]     m_axis_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output int               fail_count_o,
  output int               pending_o,
  output int               drawn_o,
  output int               culled_o
);

  typedef logic signed [127:0] wide_t;

  localparam longint CullScale = 262144;

  // camera register shadow
  logic [59:0] cam_pos;
  logic [47:0] right_ax, up_ax, fwd_ax;
  logic [23:0] focal;
  logic [12:0] scr_w, scr_h;

  // outstanding projections, oldest at rd_cnt
  logic [191:0] exp_store [int];
  int wr_cnt = 0;
  int rd_cnt = 0;

  // Sign-extend a w-bit field starting at bit lsb
  function automatic wide_t sfield(input logic [63:0] v, input int lsb, input int w);
    logic [63:0] sh;
    sh = (v >> lsb) << (64 - w);
    return wide_t'($signed(sh) >>> (64 - w));
  endfunction

  // trunc(num/(256 z) + (size+1)/2), saturated to 16 bits
  function automatic logic [15:0] to_pixel(input wide_t num, input wide_t z,
                                           input logic [12:0] size);
    wide_t t, den, q;
    t = 2 * num + 256 * z * (wide_t'({1'b0, size}) + 1);
    den = 512 * z;
    if (den < 0) begin
      t = -t;
      den = -den;
    end
    q = t / den;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Transform, cull and project one triangle; returns 1 when it is drawn
  function automatic bit project_triangle(input logic [183:0] tri_w,
                                          output logic [191:0] scr);
    wide_t d[3];
    wide_t cam[3][3];
    wide_t r[3][3];
    wide_t u1[3], u2[3], nrm[3], sum[3];
    wide_t dot, iz;
    logic [63:0] axes[3];
    logic [15:0] sx, sy;
    axes[0] = 64'(right_ax);
    axes[1] = 64'(up_ax);
    axes[2] = 64'(fwd_ax);
    scr = '0;
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++)
        d[k] = sfield(64'(tri_w[20*(3*v+k) +: 20]), 0, 20)
             - sfield(64'(cam_pos), 20*k, 20);
      for (int a = 0; a < 3; a++) begin
        cam[v][a] = 0;
        for (int k = 0; k < 3; k++)
          cam[v][a] += d[k] * sfield(axes[a], 16*k, 16);
      end
      // drop on near depth
      if (cam[v][2] < wide_t'(NearLimit) && cam[v][2] > -wide_t'(NearLimit))
        return 0;
      for (int k = 0; k < 3; k++)
        r[v][k] = cam[v][k] / CullScale;
    end
    for (int k = 0; k < 3; k++) begin
      u1[k] = r[1][k] - r[0][k];
      u2[k] = r[2][k] - r[0][k];
      sum[k] = r[0][k] + r[1][k] + r[2][k];
    end
    nrm[0] = u1[1] * u2[2] - u1[2] * u2[1];
    nrm[1] = u1[2] * u2[0] - u1[0] * u2[2];
    nrm[2] = u1[0] * u2[1] - u1[1] * u2[0];
    if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0)
      return 0;
    dot = nrm[0] * sum[0] + nrm[1] * sum[1] + nrm[2] * sum[2];
    if (dot < 0)
      return 0;
    for (int v = 0; v < 3; v++) begin
      sx = to_pixel(cam[v][0] * wide_t'({1'b0, focal}), cam[v][2], scr_w);
      sy = to_pixel(-(cam[v][1] * wide_t'({1'b0, focal})), cam[v][2], scr_h);
      iz = (wide_t'(1) <<< 46) / cam[v][2];
      scr[64*v +: 64] = {iz[31:0], sy, sx};
    end
    return 1;
  endfunction

  assign pending_o = wr_cnt - rd_cnt;

  // Track registers, predict triangles, check words
  always @(posedge clk_i or negedge rst_ni) begin
    logic [191:0] want, got;
    string names[3];
    names[0] = "screen_x";
    names[1] = "screen_y";
    names[2] = "inv_depth";
    if (!rst_ni) begin
      cam_pos  <= '0;
      right_ax <= 48'd16384;
      up_ax    <= 48'd1073741824;
      fwd_ax   <= 48'd70368744177664;
      focal    <= 24'd65536;
      scr_w    <= 13'd640;
      scr_h    <= 13'd480;
      fail_count_o <= 0;
      drawn_o  <= 0;
      culled_o <= 0;
      exp_store.delete();
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          RegCamPos:  cam_pos  <= pwdata[59:0];
          RegRight:   right_ax <= pwdata[47:0];
          RegUp:      up_ax    <= pwdata[47:0];
          RegForward: fwd_ax   <= pwdata[47:0];
          RegFocal:   focal    <= pwdata[23:0];
          RegWidth:   scr_w    <= pwdata[12:0];
          RegHeight:  scr_h    <= pwdata[12:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (project_triangle(s_axis_tdata, want)) begin
          exp_store[wr_cnt] = want;
          wr_cnt++;
          drawn_o <= drawn_o + 1;
        end else begin
          culled_o <= culled_o + 1;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (wr_cnt == rd_cnt) begin
          $display("%0t: unexpected word, expected none actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = exp_store[rd_cnt];
          exp_store.delete(rd_cnt);
          rd_cnt++;
          // compare per vertex and field
          for (int v = 0; v < 3; v++) begin
            if (want[64*v +: 16] !== got[64*v +: 16])
              $display("%0t: vertex %0d %s expected %0d actual %0d", $time, v,
                       names[0], $signed(want[64*v +: 16]), $signed(got[64*v +: 16]));
            if (want[64*v+16 +: 16] !== got[64*v+16 +: 16])
              $display("%0t: vertex %0d %s expected %0d actual %0d", $time, v,
                       names[1], $signed(want[64*v+16 +: 16]),
                       $signed(got[64*v+16 +: 16]));
            if (want[64*v+32 +: 32] !== got[64*v+32 +: 32])
              $display("%0t: vertex %0d %s expected %0d actual %0d", $time, v,
                       names[2], $signed(want[64*v+32 +: 32]),
                       $signed(got[64*v+32 +: 32]));
          end
          if (want !== got)
            fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

endmodule

@@ tb/triangle_view_project_cull_core_tb.sv @@
// ----------------------------------------------------------------------------
// triangle_view_project_cull_core_tb: stimulus and verdict for the cull core
// Programs several camera setups over APB, among them the register extremes,
// then streams directed and random triangles with bursty input and a
// stalling output, including one long output hold-off. The checker beside
// the core predicts and compares every output word.
// ----------------------------------------------------------------------------
module triangle_view_project_cull_core_tb;
  import tvpc_pkg::*;

  localparam int IdleLimit = 3000;
  localparam logic [15:0] AxPos = 16'h4000;
  localparam logic [15:0] AxNeg = 16'hC000;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [183:0]     s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [191:0]     m_axis_tdata;
  logic             psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [63:0]      pwdata, prdata;

  int fail_count, pending, drawn, culled;
  int sent;
  int burst_left, idle_cycles;
  bit hold_req;
  // camera offset and depth direction for well-formed triangles
  int cam_x, cam_y, cam_z, depth_sign;

  triangle_view_project_cull_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  triangle_view_project_cull_core_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending),
    .drawn_o(drawn), .culled_o(culled)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Pack nine world coordinates, a_x in the lowest bits
  function automatic logic [183:0] pack_tri(input int ax, ay, az, bx, by, bz,
                                            cx, cy, cz);
    logic [183:0] w;
    w = '0;
    w[19:0]    = ax[19:0];
    w[39:20]   = ay[19:0];
    w[59:40]   = az[19:0];
    w[79:60]   = bx[19:0];
    w[99:80]   = by[19:0];
    w[119:100] = bz[19:0];
    w[139:120] = cx[19:0];
    w[159:140] = cy[19:0];
    w[179:160] = cz[19:0];
    return w;
  endfunction

  // Random triangle in front of the camera, or pure noise
  function automatic logic [183:0] random_tri();
    int c[9];
    int spread;
    if ($urandom_range(0, 9) < 7) begin
      spread = ($urandom_range(0, 3) == 0) ? 200000 : 20000;
      for (int v = 0; v < 3; v++) begin
        c[3*v]   = cam_x + $urandom_range(0, 2*spread) - spread;
        c[3*v+1] = cam_y + $urandom_range(0, 2*spread) - spread;
        c[3*v+2] = cam_z + depth_sign * int'($urandom_range(1, spread));
      end
    end else begin
      for (int i = 0; i < 9; i++)
        c[i] = $urandom_range(0, 20'hFFFFF);
    end
    return pack_tri(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
  endfunction

  // Offer one triangle, with bursts and random gaps
  task automatic send_tri(input logic [183:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = w;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    sent++;
  endtask

  // APB write: setup cycle, then access cycle
  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [63:0] data);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Let the pipeline drain, culled triangles included
  task automatic drain();
    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic set_camera(input int x, y, z, input logic [47:0] r, u, f,
                            input logic [23:0] fl, input logic [12:0] w, h);
    cam_x = x; cam_y = y; cam_z = z;
    reg_write(RegCamPos, {4'b0, z[19:0], y[19:0], x[19:0]});
    reg_write(RegRight, {16'b0, r});
    reg_write(RegUp, {16'b0, u});
    reg_write(RegForward, {16'b0, f});
    reg_write(RegFocal, {40'b0, fl});
    reg_write(RegWidth, {51'b0, w});
    reg_write(RegHeight, {51'b0, h});
  endtask

  task automatic run_random(input int n);
    repeat (n) send_tri(random_tri());
  endtask

  // Output side: random stall modes, plus a long hold-off on request
  initial begin
    int mode, left;
    m_axis_tready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 80);
      end
      left--;
      case (mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = ($urandom_range(0, 3) != 0);
        default: m_axis_tready = $urandom_range(0, 1);
      endcase
    end
  end

  // Watchdog on cycles without any accepted word or APB access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("%0t: no progress", $time);
      $display("triangle_view_project_cull_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [47:0] rnd_ax[3];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sent = 0; burst_left = 0; idle_cycles = 0; hold_req = 1'b0;
    cam_x = 0; cam_y = 0; cam_z = 0; depth_sign = 1;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // default camera: extremes, near depth, winding, degenerate, saturation
    send_tri(pack_tri(524287, 524287, 524287, 524287, 524287, 524287,
                      524287, 524287, 524287));
    send_tri(pack_tri(-524288, -524288, -524288, -524288, -524288, -524288,
                      -524288, -524288, -524288));
    send_tri(pack_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tri(pack_tri(0, 0, 1024, 1600, 0, 1024, 0, 1600, 1024));
    send_tri(pack_tri(0, 0, 1024, 0, 1600, 1024, 1600, 0, 1024));
    send_tri(pack_tri(0, 0, -1024, 1600, 0, -1024, 0, 1600, -1024));
    send_tri(pack_tri(0, 0, -1024, 0, 1600, -1024, 1600, 0, -1024));
    send_tri(pack_tri(0, 0, 2, 1600, 0, 1024, 0, 1600, 1024));
    send_tri(pack_tri(0, 0, -2, 1600, 0, 1024, 0, 1600, 1024));
    send_tri(pack_tri(0, 0, 3, 1600, 0, 3, 0, 1600, 3));
    send_tri(pack_tri(0, 0, -3, 1600, 0, -3, 0, 1600, -3));
    send_tri(pack_tri(0, 0, 1024, 800, 800, 1024, 1600, 1600, 1024));
    send_tri(pack_tri(0, 0, 1024, 8, 0, 1024, 0, 8, 1024));
    send_tri(pack_tri(-524288, 524287, 3, 524287, -524288, 3, 524287, 524287, 3));
    send_tri(pack_tri(524287, -524288, 3, -524288, 524287, 3, -524288, -524288, 3));
    send_tri(pack_tri(0, 0, 524287, 524287, 0, 524287, 0, 524287, 524287));
    send_tri(pack_tri(0, 0, 1024, 1600, 0, 2048, 0, 1600, 4096));
    run_random(100);
    drain();

    // mirrored axes, camera off origin, looking down negative z
    depth_sign = -1;
    set_camera($urandom_range(0, 100000) - 50000, $urandom_range(0, 100000) - 50000,
               $urandom_range(0, 100000) - 50000, {16'h0, 16'h0, AxNeg},
               {16'h0, AxPos, 16'h0}, {AxNeg, 16'h0, 16'h0},
               24'($urandom_range(1, 24'hFFFFFF)), 13'($urandom_range(1, 4096)),
               13'($urandom_range(1, 4096)));
    run_random(40);
    hold_req = 1'b1;
    run_random(60);
    drain();

    // extremes: camera at all ones, widest focal, tall and flat screens
    depth_sign = 1;
    set_camera(-1, -1, -1, {16'h0, 16'h0, AxPos}, {16'h0, AxNeg, 16'h0},
               {AxPos, 16'h0, 16'h0}, 24'hFFFFFF, 13'd4096, 13'd1);
    run_random(80);
    drain();
    set_camera(0, 0, 0, {16'h0, 16'h0, AxPos}, {16'h0, AxPos, 16'h0},
               {AxPos, 16'h0, 16'h0}, 24'h0, 13'd0, 13'h1FFF);
    run_random(60);
    drain();

    // fully random registers, mostly culled
    for (int i = 0; i < 3; i++)
      rnd_ax[i] = {16'($urandom), 32'($urandom)};
    set_camera($urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
               $urandom_range(0, 20'hFFFFF), rnd_ax[0], rnd_ax[1], rnd_ax[2],
               24'($urandom), 13'($urandom), 13'($urandom));
    run_random(60);
    drain();

    // narrow screen, short focal
    set_camera(0, 0, 0, {16'h0, 16'h0, AxPos}, {16'h0, AxPos, 16'h0},
               {AxPos, 16'h0, 16'h0}, 24'($urandom_range(1, 4096)), 13'd1,
               13'd4096);
    run_random(100);
    drain();
    repeat (40) @(negedge clk_i);

    $display("Sent %0d triangles over six camera setups: %0d drawn, %0d culled.",
             sent, drawn, culled);
    if (fail_count == 0 && pending == 0)
      $display("triangle_view_project_cull_core_tb: PASS");
    else
      $display("triangle_view_project_cull_core_tb: FAIL");
    $finish;
  end

endmodule

@@ triangle_view_project_cull_core.f @@
rtl/tvpc_pkg.sv
rtl/tvpc_xform.sv
rtl/tvpc_div.sv
rtl/triangle_view_project_cull_core.sv
rtl/tvpc_checker.sv
tb/triangle_view_project_cull_core_checker.sv
tb/triangle_view_project_cull_core_tb.sv
